// ===== sv/cbd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the C-alpha chain break detector.
// No dependencies; used by every module of the block.
package cbd_pkg;

  localparam int COORD_W      = 25;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int SQ_W         = 2 * DIFF_W;
  localparam int SUM_W        = SQ_W + 2;
  localparam int CUT_W        = 16;
  localparam int CUT2_W       = 2 * CUT_W;
  localparam logic [CUT_W-1:0] CUTOFF_RESET = 16'd4000;

  localparam int Q_DEPTH      = 4;
  localparam int Q_AW         = 2;

  localparam int IN_TDATA_W   = 80;
  localparam int IN_TUSER_W   = 4;
  localparam int OUT_TDATA_W  = 8;

  // in_tuser bit positions
  localparam int TU_IS_CALPHA  = 0;
  localparam int TU_ATOM_VALID = 1;
  localparam int TU_RES_VALID  = 2;
  localparam int TU_CHAIN_LAST = 3;

  typedef logic signed [COORD_W-1:0] coord_t;

  // one residue-end job handed from front to back
  typedef struct packed {
    logic   flag;   // previous residue gets a break flag
    logic   cmp;    // flag decided by distance compare (else forced to 1)
    logic   close;  // closing chain-end result follows
    coord_t px;
    coord_t py;
    coord_t pz;
    coord_t cx;
    coord_t cy;
    coord_t cz;
  } cbd_job_t;

endpackage

// ===== sv/calpha_chain_break_detector_core.sv =====
`timescale 1ns / 1ps
// C-alpha chain break detector top level. An accepted residue-end atom passes the
// job queue and the s1, s2, e and output registers to its first result; a chain
// end adds the closing result after it. One atom is taken per cycle while results
// drain; an atom that yields a flag and the closing result issues two results and
// the 4-entry job queue absorbs the burst. Synchronous active-low reset clears
// the residue flags, the queue and the pipeline; cutoff returns to 4000 (4.000 A).
module calpha_chain_break_detector_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [cbd_pkg::CUT_W-1:0]          cfg_wr_data,   // cutoff_milli
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // coord_x [24:0], coord_y [49:25], coord_z [74:50], zero [79:75]
  input  logic [cbd_pkg::IN_TDATA_W-1:0]     in_tdata,
  // is_calpha [0], atom_valid [1], residue_has_valid [2], chain_last [3]
  input  logic [cbd_pkg::IN_TUSER_W-1:0]     in_tuser,
  input  logic                               in_tlast,      // residue_end
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // break_flag [0], zero [7:1]
  output logic [cbd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tuser,     // chain_end
  output logic                               out_tlast      // last_of_run
);

  logic              accept, push, q_full, q_valid, q_pop;
  cbd_pkg::cbd_job_t job_in, job_out;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  cbd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_tdata),
    .in_user (in_tuser),
    .in_last (in_tlast),
    .push    (push),
    .job     (job_in)
  );

  cbd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din       (job_in),
    .pop       (q_pop),
    .dout      (job_out),
    .full      (q_full),
    .not_empty (q_valid)
  );

  cbd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_job       (job_out),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

// ===== sv/cbd_front.sv =====
`timescale 1ns / 1ps
// Front end: tracks current/previous residue C-alpha and builds residue-end jobs.
// Depends on cbd_pkg.
module cbd_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [cbd_pkg::IN_TDATA_W-1:0] in_data,
  input  logic [cbd_pkg::IN_TUSER_W-1:0] in_user,
  input  logic                         in_last,
  output logic                         push,
  output cbd_pkg::cbd_job_t            job
);

  logic            have_prev_r, prev_valid_r, prev_has_r, cur_has_r;
  cbd_pkg::coord_t prev_x_r, prev_y_r, prev_z_r;
  cbd_pkg::coord_t cur_x_r, cur_y_r, cur_z_r;

  cbd_pkg::coord_t ax, ay, az, ex, ey, ez;
  logic            take_ca, eff_has, res_valid, chain_last;

  always_comb begin
    ax = in_data[cbd_pkg::COORD_W-1:0];
    ay = in_data[2*cbd_pkg::COORD_W-1:cbd_pkg::COORD_W];
    az = in_data[3*cbd_pkg::COORD_W-1:2*cbd_pkg::COORD_W];
    res_valid  = in_user[cbd_pkg::TU_RES_VALID];
    chain_last = in_user[cbd_pkg::TU_CHAIN_LAST];
    // only the first valid C-alpha of a residue is kept
    take_ca = in_user[cbd_pkg::TU_IS_CALPHA] && in_user[cbd_pkg::TU_ATOM_VALID] && !cur_has_r;
    eff_has = cur_has_r || take_ca;
    ex = take_ca ? ax : cur_x_r;
    ey = take_ca ? ay : cur_y_r;
    ez = take_ca ? az : cur_z_r;

    job.flag  = have_prev_r && prev_valid_r;
    job.cmp   = prev_has_r && res_valid && eff_has;
    job.close = chain_last;
    job.px = prev_x_r;
    job.py = prev_y_r;
    job.pz = prev_z_r;
    job.cx = ex;
    job.cy = ey;
    job.cz = ez;
    push = accept && in_last && (job.flag || job.close);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r  <= 1'b0;
      prev_valid_r <= 1'b0;
      prev_has_r   <= 1'b0;
      cur_has_r    <= 1'b0;
    end else if (accept) begin
      if (!in_last) begin
        cur_has_r <= eff_has;
      end else begin
        cur_has_r <= 1'b0;
        if (chain_last) begin
          have_prev_r  <= 1'b0;
          prev_valid_r <= 1'b0;
          prev_has_r   <= 1'b0;
        end else begin
          have_prev_r  <= 1'b1;
          prev_valid_r <= res_valid;
          prev_has_r   <= eff_has;
        end
      end
    end
  end

  // coordinates are qualified by the has flags
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_x_r <= ex;
      cur_y_r <= ey;
      cur_z_r <= ez;
      if (in_last) begin
        prev_x_r <= ex;
        prev_y_r <= ey;
        prev_z_r <= ez;
      end
    end
  end

endmodule

// ===== sv/cbd_queue.sv =====
`timescale 1ns / 1ps
// Short job queue between front and back ends.
// Depends on cbd_pkg.
module cbd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cbd_pkg::cbd_job_t din,
  input  logic              pop,
  output cbd_pkg::cbd_job_t dout,
  output logic              full,
  output logic              not_empty
);

  cbd_pkg::cbd_job_t             slot_r [cbd_pkg::Q_DEPTH];
  logic [cbd_pkg::Q_AW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [cbd_pkg::Q_AW:0]        count_r;

  assign full      = (count_r == (cbd_pkg::Q_AW+1)'(cbd_pkg::Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign dout      = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= din;
  end

endmodule

// ===== sv/cbd_back.sv =====
`timescale 1ns / 1ps
// Back end: squared C-alpha distance pipeline, cutoff compare and result issue.
// Depends on cbd_pkg.
module cbd_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [cbd_pkg::CUT_W-1:0]        cfg_wr_data,
  input  logic                             q_valid,
  input  cbd_pkg::cbd_job_t                q_job,
  output logic                             q_pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [cbd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tuser,
  output logic                             out_tlast
);

  logic [cbd_pkg::CUT_W-1:0]  cutoff_r;
  logic [cbd_pkg::CUT2_W-1:0] cut2_r;

  logic                       s1_v_r, s1_flag_r, s1_cmp_r, s1_close_r;
  logic [cbd_pkg::DIFF_W-1:0] s1_ax_r, s1_ay_r, s1_az_r;
  logic                       s2_v_r, s2_flag_r, s2_cmp_r, s2_close_r;
  logic [cbd_pkg::SQ_W-1:0]   s2_sx_r, s2_sy_r, s2_sz_r;
  logic                       e_flag_r, e_close_r, e_brk_r;
  logic                       out_valid_r, out_brk_r, out_cend_r, out_last_r;

  logic                       out_free, e_busy, e_free, s2_free, s1_free, s2_go, brk;
  logic [cbd_pkg::DIFF_W-1:0] ax, ay, az;
  logic [cbd_pkg::SUM_W-1:0]  dist2;

  function automatic logic [cbd_pkg::DIFF_W-1:0] abs_diff(cbd_pkg::coord_t a,
                                                          cbd_pkg::coord_t b);
    logic signed [cbd_pkg::DIFF_W-1:0] d;
    d = {a[cbd_pkg::COORD_W-1], a} - {b[cbd_pkg::COORD_W-1], b};
    return d[cbd_pkg::DIFF_W-1] ? -d : d;
  endfunction

  always_comb begin
    out_free = !out_valid_r || out_tready;
    e_busy   = e_flag_r || e_close_r;
    // stage is free once its last pending result leaves this cycle
    e_free   = !e_busy || (out_free && !(e_flag_r && e_close_r));
    s2_free  = !s2_v_r || e_free;
    s2_go    = s2_v_r && e_free;
    s1_free  = !s1_v_r || s2_free;
    q_pop    = q_valid && s1_free;

    ax = abs_diff(q_job.px, q_job.cx);
    ay = abs_diff(q_job.py, q_job.cy);
    az = abs_diff(q_job.pz, q_job.cz);

    dist2 = cbd_pkg::SUM_W'(s2_sx_r) + cbd_pkg::SUM_W'(s2_sy_r) + cbd_pkg::SUM_W'(s2_sz_r);
    brk   = !(s2_cmp_r && (dist2 <= cbd_pkg::SUM_W'(cut2_r)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= cbd_pkg::CUTOFF_RESET;
    end else if (cfg_wr_en) begin
      cutoff_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    cut2_r <= cutoff_r * cutoff_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      e_flag_r    <= 1'b0;
      e_close_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free) s1_v_r <= q_valid;
      if (s2_free) s2_v_r <= s1_v_r;

      if (s2_go) begin
        e_flag_r  <= s2_flag_r;
        e_close_r <= s2_close_r;
      end else if (out_free && e_busy) begin
        if (e_flag_r) e_flag_r  <= 1'b0;
        else          e_close_r <= 1'b0;
      end

      if (out_free) out_valid_r <= e_busy;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_flag_r  <= q_job.flag;
      s1_cmp_r   <= q_job.cmp;
      s1_close_r <= q_job.close;
      s1_ax_r    <= ax;
      s1_ay_r    <= ay;
      s1_az_r    <= az;
    end
    if (s2_free) begin
      s2_flag_r  <= s1_flag_r;
      s2_cmp_r   <= s1_cmp_r;
      s2_close_r <= s1_close_r;
      s2_sx_r    <= s1_ax_r * s1_ax_r;
      s2_sy_r    <= s1_ay_r * s1_ay_r;
      s2_sz_r    <= s1_az_r * s1_az_r;
    end
    if (s2_go) e_brk_r <= brk;
    if (out_free) begin
      out_brk_r  <= e_flag_r && e_brk_r;
      out_cend_r <= !e_flag_r;
      out_last_r <= !(e_flag_r && e_close_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(cbd_pkg::OUT_TDATA_W-1)'(0), out_brk_r};
  assign out_tuser  = out_cend_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== sv/cbd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the C-alpha chain break detector, bound to the top level.
// Depends on cbd_pkg and calpha_chain_break_detector_core.
module cbd_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [cbd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input logic                               out_tuser,
  input logic                               out_tlast
);

  // no result straight after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // closing result never flags a break and always ends the run
  a_close_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> !out_tdata[0] && out_tlast)
    else $error("malformed chain-end result");

  // a flag that is not last is followed at once by the closing result
  a_close_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tuser)
    else $error("chain-end result missing after flag");

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("stalled result changed");

endmodule

bind calpha_chain_break_detector_core cbd_checker u_cbd_checker (.*);

// ===== bench/calpha_chain_break_detector_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for calpha_chain_break_detector_core: streams atoms grouped into
// residues and chains, predicts each break flag as atoms are taken and checks every result.
// Depends on cbd_pkg and the core RTL only.
module calpha_chain_break_detector_core_test;
  import cbd_pkg::*;

  typedef struct packed {
    logic break_flag;
    logic chain_end;
    logic last_of_run;
  } flag_rec_t;

  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam longint WALK_MIN  = -(longint'(1) << (COORD_W-1));
  localparam longint WALK_MAX  = (longint'(1) << (COORD_W-1)) - 1;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   cfg_wr_en   = 1'b0;
  logic [CUT_W-1:0]       cfg_wr_data = '0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic [IN_TUSER_W-1:0]  in_tuser    = '0;
  logic                   in_tlast    = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b1;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  // predictor state: last closed residue and the residue being received
  logic [CUT_W-1:0] cutoff_mirror = CUTOFF_RESET;
  bit               prev_seen, prev_res_valid, prev_ca_seen;
  coord_t           prev_ca_x = '0, prev_ca_y = '0, prev_ca_z = '0;
  bit               open_ca_seen;
  coord_t           open_ca_x = '0, open_ca_y = '0, open_ca_z = '0;

  flag_rec_t pending_flags[$];
  flag_rec_t want;
  int        fail_count = 0;
  int        atoms_sent = 0;
  int        send_calm  = 0;
  int        stall_left = 0;
  int        sink_calm  = 0;
  int        sink_roll;

  calpha_chain_break_detector_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic predict_flags(input coord_t x, y, z, input bit ca, av, rv, rend, clast);
    longint    dx, dy, dz;
    flag_rec_t recs[2];
    int        n;
    n = 0;
    if (ca && av && !open_ca_seen) begin
      open_ca_seen = 1'b1;
      open_ca_x = x;
      open_ca_y = y;
      open_ca_z = z;
    end
    if (rend) begin
      if (prev_seen && prev_res_valid) begin
        recs[n] = '{break_flag: 1'b1, chain_end: 1'b0, last_of_run: 1'b0};
        if (prev_ca_seen && rv && open_ca_seen) begin
          dx = longint'(prev_ca_x) - longint'(open_ca_x);
          dy = longint'(prev_ca_y) - longint'(open_ca_y);
          dz = longint'(prev_ca_z) - longint'(open_ca_z);
          if (dx * dx + dy * dy + dz * dz <= longint'(cutoff_mirror) * longint'(cutoff_mirror))
            recs[n].break_flag = 1'b0;
        end
        n++;
      end
      if (clast) begin
        recs[n] = '{break_flag: 1'b0, chain_end: 1'b1, last_of_run: 1'b0};
        n++;
        prev_seen = 1'b0;
        prev_res_valid = 1'b0;
        prev_ca_seen = 1'b0;
        prev_ca_x = '0;
        prev_ca_y = '0;
        prev_ca_z = '0;
      end else begin
        prev_seen = 1'b1;
        prev_res_valid = rv;
        prev_ca_seen = open_ca_seen;
        prev_ca_x = open_ca_x;
        prev_ca_y = open_ca_y;
        prev_ca_z = open_ca_z;
      end
      open_ca_seen = 1'b0;
      open_ca_x = '0;
      open_ca_y = '0;
      open_ca_z = '0;
      if (n > 0) recs[n-1].last_of_run = 1'b1;
      for (int i = 0; i < n; i++) pending_flags.push_back(recs[i]);
    end
  endtask

  // mostly back-to-back, some short gaps, a few long ones, now and then a gap-free stretch
  function automatic int sender_gap();
    int r;
    if (send_calm > 0) begin
      send_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      send_calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_atom(input coord_t x, y, z, input bit ca, av, rv, rend, clast);
    logic [IN_TUSER_W-1:0] tu;
    int gap;
    gap = sender_gap();
    tu = '0;
    tu[TU_IS_CALPHA]  = ca;
    tu[TU_ATOM_VALID] = av;
    tu[TU_RES_VALID]  = rv;
    tu[TU_CHAIN_LAST] = clast;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {{(IN_TDATA_W - 3*COORD_W){1'b0}}, z, y, x};
    in_tuser  = tu;
    in_tlast  = rend;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_flags(x, y, z, ca, av, rv, rend, clast);
    atoms_sent++;
  endtask

  // drop valid and wait for the pipeline to empty
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_flags.size() != 0) @(posedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_cutoff(input logic [CUT_W-1:0] value);
    settle();
    cfg_wr_data = value;
    cfg_wr_en   = 1'b1;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    cutoff_mirror = value;
  endtask

  function automatic longint walk_step(input longint p, input longint d);
    if (p + d > WALK_MAX || p + d < WALK_MIN) return p - d;
    return p + d;
  endfunction

  function automatic longint near_offset(input int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic gen_chain(input int n_res);
    longint px, py, pz, dx, dy, dz;
    int     n_atoms, ca_pos, pick, span;
    bit     rv, has_ca, end_atom;
    px = longint'($urandom_range(0, 16000000)) - 8000000;
    py = longint'($urandom_range(0, 16000000)) - 8000000;
    pz = longint'($urandom_range(0, 16000000)) - 8000000;
    for (int r = 0; r < n_res; r++) begin
      pick = $urandom_range(0, 9);
      span = int'(cutoff_mirror) * 7 / 10 + 1;
      dx = 0;
      dy = 0;
      dz = 0;
      if (pick == 1 || pick == 2) begin
        // right on the cutoff along one axis, give or take one
        dx = longint'(cutoff_mirror) + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1)) dx = -dx;
      end else if (pick >= 3 && pick <= 7) begin
        dx = near_offset(span);
        dy = near_offset(span);
        dz = near_offset(span);
      end else if (pick >= 8) begin
        dx = near_offset(100000);
        dy = near_offset(100000);
        dz = near_offset(100000);
      end
      px = walk_step(px, dx);
      py = walk_step(py, dy);
      pz = walk_step(pz, dz);
      n_atoms = $urandom_range(1, 5);
      has_ca  = ($urandom_range(0, 9) != 0);
      ca_pos  = $urandom_range(0, n_atoms - 1);
      rv      = ($urandom_range(0, 99) < 85);
      for (int a = 0; a < n_atoms; a++) begin
        end_atom = (a == n_atoms - 1);
        if (has_ca && a == ca_pos)
          send_atom(coord_t'(px), coord_t'(py), coord_t'(pz), 1'b1,
                    ($urandom_range(0, 19) != 0),
                    end_atom ? rv : bit'($urandom_range(0, 1)), end_atom,
                    end_atom ? (r == n_res - 1) : ($urandom_range(0, 9) == 0));
        else
          send_atom(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                    ($urandom_range(0, 9) == 0), ($urandom_range(0, 4) != 0),
                    end_atom ? rv : bit'($urandom_range(0, 1)), end_atom,
                    end_atom ? (r == n_res - 1) : ($urandom_range(0, 9) == 0));
      end
    end
  endtask

  // residue validity, chain_last inside residue, repeated and invalid C-alphas,
  // invalid residues, missing C-alpha, single-residue chain, cutoff boundary
  task automatic test_residue_rules();
    send_atom(0, 0, 0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1);
    send_atom(0, 0, 0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    send_atom(100, 100, 100, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    send_atom(4000, 0, 0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
    send_atom(4000, 0, 0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    send_atom(6400, 3200, 0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    send_atom(10401, 3200, 0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    send_atom(10401, 3200, 0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
    send_atom(10401, 3200, 0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    send_atom(0, 0, 0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
    send_atom(0, 0, 0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    send_atom(-7, 7, -7, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    send_atom(0, 0, 0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
    send_atom(0, 0, 0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
    send_atom(0, 0, 0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_coord_extremes();
    send_atom(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    send_atom(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_cutoff_extremes();
    write_cutoff('0);
    send_atom(5, -5, 7, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    send_atom(5, -5, 7, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    send_atom(6, -5, 7, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    write_cutoff('1);
    send_atom(0, 0, 0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    send_atom(65535, 0, 0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    send_atom(131070, 0, 1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_random_stream();
    int target, next_phase, phase;
    target = atoms_sent + 1850;
    next_phase = atoms_sent;
    phase = 0;
    while (atoms_sent < target) begin
      if (atoms_sent >= next_phase) begin
        case (phase % 4)
          0:       write_cutoff(CUTOFF_RESET);
          1:       write_cutoff('1);
          2:       write_cutoff('0);
          default: write_cutoff(CUT_W'($urandom_range(0, 65535)));
        endcase
        phase++;
        next_phase = atoms_sent + 450;
      end
      if ($urandom_range(0, 99) < 85)
        gen_chain($urandom_range(1, 8));
      else
        repeat ($urandom_range(1, 4))
          send_atom(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                    $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                    $urandom_range(0, 1), $urandom_range(0, 1));
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    test_residue_rules();
    test_coord_extremes();
    test_cutoff_extremes();
    test_random_stream();
    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_flags.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // result side: stalls of random length with calm stretches in between
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_tready = 1'b0;
    end else if (sink_calm > 0) begin
      sink_calm = sink_calm - 1;
      out_tready = 1'b1;
    end else begin
      sink_roll = $urandom_range(0, 99);
      if (sink_roll < 3) begin
        sink_calm = $urandom_range(20, 80);
        out_tready = 1'b1;
      end else if (sink_roll < 25) begin
        stall_left = $urandom_range(0, 2);
        out_tready = 1'b0;
      end else if (sink_roll < 30) begin
        stall_left = $urandom_range(5, 30);
        out_tready = 1'b0;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  task automatic note_mismatch(input string field, input logic want_v, got_v);
    $error("%s mismatch: expected %0b, got %0b", field, want_v, got_v);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_flags.size() == 0) begin
        $error("result transaction with nothing pending: break_flag %0b chain_end %0b",
               out_tdata[0], out_tuser);
        fail_count++;
      end else begin
        want = pending_flags.pop_front();
        if (out_tdata[0] !== want.break_flag) note_mismatch("break_flag", want.break_flag,
                                                           out_tdata[0]);
        if (out_tuser !== want.chain_end) note_mismatch("chain_end", want.chain_end, out_tuser);
        if (out_tlast !== want.last_of_run) note_mismatch("last_of_run", want.last_of_run,
                                                         out_tlast);
      end
    end
  end

endmodule
